>>> hw/rtl/damr_pkg.sv
package damr_pkg;

	// Result is formed as an integer scaled by 2^56 in both modes
	localparam int unsigned FRAC_SH    = 56;
	localparam int unsigned ADD_ALIGN  = 16;   // add mode product is Q.40, lifted to Q.56
	localparam int unsigned MAG_W      = 43;   // |dequantised value| or |sum|, Q.24
	localparam int unsigned MAGLO_W    = 32;
	localparam int unsigned MAGHI_W    = MAG_W - MAGLO_W;
	localparam int unsigned MULB_W     = 64;   // second factor: inv scale or |op|*inv scale
	localparam int unsigned PROD_W     = MAG_W + MULB_W;
	localparam int unsigned QT_W       = PROD_W - FRAC_SH;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		CFG_IN_SCALE      = 3'd0,
		CFG_IN_ZERO       = 3'd1,
		CFG_IN_SIGNED     = 3'd2,
		CFG_OUT_INV_SCALE = 3'd3,
		CFG_OUT_ZERO      = 3'd4,
		CFG_OUT_SIGNED    = 3'd5,
		CFG_OP_MODE       = 3'd6
	} cfg_idx_t;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_MUL = 1'b1
	} op_mode_t;

	typedef struct packed {
		logic [31:0] in_scale;
		logic [8:0]  in_zero;
		logic        in_signed;
		logic [31:0] out_inv_scale;
		logic [8:0]  out_zero;
		logic        out_signed;
		logic        op_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_scale:      32'h0100_0000,
		in_zero:       9'd0,
		in_signed:     1'b0,
		out_inv_scale: 32'h0001_0000,
		out_zero:      9'd0,
		out_signed:    1'b0,
		op_mode:       1'b0
	};

	typedef struct packed {
		logic [7:0]         code_in;
		logic signed [31:0] operand_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_out;
		logic       status;
		logic       clipped;
	} out_item_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic               mul;      // multiply mode
		logic               zs;       // reciprocal output scale is zero
		logic               neg_mul;  // sign of the product in multiply mode
		logic signed [9:0]  d;        // code minus input zero
		logic signed [31:0] opv;      // operand, Q16.16
		logic [31:0]        op_mag;   // |operand|
	} item_t;

endpackage

>>> hw/rtl/damr_front.sv
module damr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  damr_pkg::cfg_t     cfg,
	input  logic               item_valid,
	input  damr_pkg::in_item_t item,
	output logic               item_stall,
	input  logic               fifo_full,
	output logic               push,
	output damr_pkg::item_t    wr_item
);
	import damr_pkg::*;

	logic              fe_valid_s1;
	item_t             fe_item_s1;
	item_t             cls;
	logic signed [9:0] code_ext;
	logic signed [9:0] zero_ext;

	always_comb begin
		code_ext = cfg.in_signed ? {{2{item.code_in[7]}}, item.code_in}
		                         : {2'b00, item.code_in};
		zero_ext = {cfg.in_zero[8], cfg.in_zero};
		cls.d       = code_ext - zero_ext;
		cls.opv     = item.operand_in;
		cls.op_mag  = item.operand_in[31] ? (~item.operand_in + 32'd1) : item.operand_in;
		cls.neg_mul = cls.d[9] ^ item.operand_in[31];
		cls.mul     = (op_mode_t'(cfg.op_mode) == OP_MUL);
		cls.zs      = (cfg.out_inv_scale == 32'd0);
	end

	assign item_stall = fe_valid_s1 & fifo_full;
	assign push       = fe_valid_s1 & ~fifo_full;
	assign wr_item    = fe_item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			fe_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			fe_item_s1 <= cls;
		end
	end

endmodule

>>> hw/rtl/damr_fifo.sv
module damr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  damr_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output damr_pkg::item_t rd_item,
	output logic            empty
);
	import damr_pkg::*;

	item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> hw/rtl/damr_back.sv
module damr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  damr_pkg::cfg_t      cfg,
	input  damr_pkg::item_t     rd_item,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output damr_pkg::out_item_t result
);
	import damr_pkg::*;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// s1: dequantise product and operand times reciprocal scale
	logic               mul_s1, zs_s1, negm_s1;
	logic signed [31:0] opv_s1;
	logic signed [42:0] pd_s1;
	logic [63:0]        pb_s1;
	logic signed [9:0]  d_c;
	logic signed [32:0] sc_c;

	// s2: magnitude and second factor
	logic               zs_s2, mul_s2, neg_s2;
	logic [MAG_W-1:0]   a_s2;
	logic [MULB_W-1:0]  b_s2;
	logic signed [43:0] x_c;
	logic [43:0]        xm_c;
	logic [42:0]        pdm_c;

	// s3: partial products
	logic               zs_s3, mul_s3, neg_s3;
	logic [63:0]        pll_s3, plh_s3;
	logic [42:0]        phl_s3, phh_s3;

	// s4: cross terms summed
	logic               zs_s4, mul_s4, neg_s4;
	logic [63:0]        pll_s4;
	logic [64:0]        mid_s4;
	logic [42:0]        phh_s4;

	// s5: full product in Q.56
	logic               zs_s5, neg_s5;
	logic [PROD_W-1:0]  p_s5;
	logic [PROD_W-1:0]  p_c;

	// s6: rounded magnitude
	logic               zs_s6, neg_s6;
	logic [31:0]        m_s6;
	logic [QT_W-1:0]    qt_c;
	logic               big_c, inc_c, rlo_c;
	logic [32:0]        mr_c;
	logic [31:0]        m_c;

	// s7: output register
	out_item_t          res_s7;
	logic signed [32:0] q_c;
	logic signed [33:0] r_c;
	logic signed [33:0] lo_c, hi_c;
	out_item_t          res_c;

	assign en           = ~(v_s7 & result_stall);
	assign pop          = en & ~empty;
	assign result_valid = v_s7;
	assign result       = res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= ~empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		d_c  = rd_item.d;
		sc_c = {1'b0, cfg.in_scale};
	end

	always_comb begin
		x_c   = {pd_s1[42], pd_s1} + {{4{opv_s1[31]}}, opv_s1, 8'd0};
		xm_c  = x_c[43] ? (~x_c + 44'd1) : x_c;
		pdm_c = pd_s1[42] ? (~pd_s1 + 43'd1) : pd_s1;
	end

	always_comb begin
		p_c = PROD_W'(pll_s4) + (PROD_W'(mid_s4) << 32) + (PROD_W'(phh_s4) << 64);
	end

	// round half to even, then clamp to the int32 magnitude range
	always_comb begin
		qt_c  = p_s5[PROD_W-1:FRAC_SH];
		rlo_c = |p_s5[FRAC_SH-2:0];
		big_c = (qt_c > QT_W'(32'h8000_0000));
		inc_c = p_s5[FRAC_SH-1] & (rlo_c | qt_c[0]);
		mr_c  = {1'b0, qt_c[31:0]} + {32'd0, inc_c};
		if (big_c || mr_c > 33'h0_8000_0000) m_c = 32'h8000_0000;
		else                                 m_c = mr_c[31:0];
		if (!neg_s5 && m_c[31]) m_c = 32'h7FFF_FFFF;
	end

	always_comb begin
		q_c = neg_s6 ? -$signed({1'b0, m_s6}) : $signed({1'b0, m_s6});
		r_c = {q_c[32], q_c} + {{25{cfg.out_zero[8]}}, cfg.out_zero};
		lo_c = cfg.out_signed ? -34'sd128 : 34'sd0;
		hi_c = cfg.out_signed ? 34'sd127  : 34'sd255;
		res_c.status = 1'b0;
		if (r_c < lo_c) begin
			res_c.code_out = lo_c[7:0];
			res_c.clipped  = 1'b1;
		end else if (r_c > hi_c) begin
			res_c.code_out = hi_c[7:0];
			res_c.clipped  = 1'b1;
		end else begin
			res_c.code_out = r_c[7:0];
			res_c.clipped  = 1'b0;
		end
		if (zs_s6) begin
			res_c.code_out = 8'd0;
			res_c.clipped  = 1'b0;
			res_c.status   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1  <= rd_item.mul;
			zs_s1   <= rd_item.zs;
			negm_s1 <= rd_item.neg_mul;
			opv_s1  <= rd_item.opv;
			pd_s1   <= d_c * sc_c;
			pb_s1   <= rd_item.op_mag * cfg.out_inv_scale;

			zs_s2  <= zs_s1;
			mul_s2 <= mul_s1;
			if (mul_s1) begin
				a_s2   <= pdm_c;
				b_s2   <= pb_s1;
				neg_s2 <= negm_s1;
			end else begin
				a_s2   <= xm_c[MAG_W-1:0];
				b_s2   <= {32'd0, cfg.out_inv_scale};
				neg_s2 <= x_c[43];
			end

			zs_s3  <= zs_s2;
			mul_s3 <= mul_s2;
			neg_s3 <= neg_s2;
			pll_s3 <= a_s2[MAGLO_W-1:0] * b_s2[31:0];
			plh_s3 <= a_s2[MAGLO_W-1:0] * b_s2[63:32];
			phl_s3 <= a_s2[MAG_W-1:MAGLO_W] * b_s2[31:0];
			phh_s3 <= a_s2[MAG_W-1:MAGLO_W] * b_s2[63:32];

			zs_s4  <= zs_s3;
			mul_s4 <= mul_s3;
			neg_s4 <= neg_s3;
			pll_s4 <= pll_s3;
			mid_s4 <= {1'b0, plh_s3} + {22'd0, phl_s3};
			phh_s4 <= phh_s3;

			zs_s5  <= zs_s4;
			neg_s5 <= neg_s4;
			p_s5   <= mul_s4 ? p_c : (p_c << ADD_ALIGN);

			zs_s6  <= zs_s5;
			neg_s6 <= neg_s5;
			m_s6   <= m_c;

			res_s7 <= res_c;
		end
	end

endmodule

>>> hw/rtl/dequant_add_mul_requant_core.sv
// Path of an input transfer to its result: front register, one queue slot,
//   seven back stages ending in the output register.
// Throughput: one item per cycle; the back pipeline moves as a whole, held only by
//   result_stall, and the four-entry queue absorbs the front/back slip.
// Reset: arst_n asynchronous, active low; clears all valids, queue pointers and
//   restores the configuration registers to their documented defaults.
module dequant_add_mul_requant_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  damr_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output damr_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import damr_pkg::*;

	cfg_t  cfg_q;

	logic  fifo_full;
	logic  fifo_empty;
	logic  push;
	logic  pop;
	item_t wr_item;
	item_t rd_item;

	// Configuration registers: always ready; writes are to be made only while idle (not
	// enforced by the block), as the datapath reads them live. Index 7 is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IN_SCALE:      cfg_q.in_scale      <= cfg_data;
				CFG_IN_ZERO:       cfg_q.in_zero       <= cfg_data[8:0];
				CFG_IN_SIGNED:     cfg_q.in_signed     <= cfg_data[0];
				CFG_OUT_INV_SCALE: cfg_q.out_inv_scale <= cfg_data;
				CFG_OUT_ZERO:      cfg_q.out_zero      <= cfg_data[8:0];
				CFG_OUT_SIGNED:    cfg_q.out_signed    <= cfg_data[0];
				CFG_OP_MODE:       cfg_q.op_mode       <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// Front: takes the input transfer, reads the code per in_signed, removes the
	// input zero point, splits the operand into sign and magnitude and tags the
	// item with its mode and the zero-scale error.
	damr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.fifo_full  (fifo_full),
		.push       (push),
		.wr_item    (wr_item)
	);

	// Short queue decoupling the front from the back pipeline
	damr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (fifo_full),
		.pop     (pop),
		.rd_item (rd_item),
		.empty   (fifo_empty)
	);

	// Back: exact products via partial products of 32- and 11-bit slices, round half
	// to even at 2^-56, clamp, add output zero point and saturate. The last stage is the
	// output register, so a stalled result does not block the queue from filling.
	damr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.rd_item      (rd_item),
		.empty        (fifo_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> hw/rtl/damr_checker.sv
module damr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input damr_pkg::out_item_t result
);

	logic [4:0] outstanding_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = item_valid & ~item_stall;
	assign out_xfer = result_valid & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |-> result.code_out == 8'd0 && !result.clipped)
		else $error("error result carries data");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outstanding_q != 5'd0)
		else $error("result without an accepted item");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 5'd0 |-> !item_stall)
		else $error("input stalled while empty");

endmodule

bind dequant_add_mul_requant_core damr_checker u_damr_checker (.*);
